[rtl/rc_stick_gesture_detector_macros.svh]
// assertion macros used by the checker file
`ifndef RC_STICK_GESTURE_DETECTOR_MACROS_SVH
`define RC_STICK_GESTURE_DETECTOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RCSG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RCSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rcsg_pkg.sv]
package rcsg_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned TimeW  = 15;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_MIN_CHECK = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_CHECK = 2'd1;

  localparam logic [ValueW-1:0] MIN_CHECK_RESET = 12'd1050;
  localparam logic [ValueW-1:0] MAX_CHECK_RESET = 12'd1900;

  localparam logic [TimeW-1:0]  HOLD_DELAY_MS     = 15'd50;
  localparam logic [CountW-1:0] DISARM_TICK_LIMIT = 8'd3;
  localparam logic [TimeW:0]    HOLD_MAX          = 16'd32767;
  localparam logic [CountW-1:0] COUNT_MAX         = 8'd255;

  localparam logic [CodeW-1:0] CODE_CALIBRATE = 8'h65;
  localparam logic [CodeW-1:0] CODE_SAVE      = 8'h56;

  // one control tick as registered at the input
  typedef struct packed {
    logic [ValueW-1:0] roll_value;
    logic [ValueW-1:0] pitch_value;
    logic [ValueW-1:0] yaw_value;
    logic [ValueW-1:0] throttle_value;
    logic [TimeW-1:0]  elapsed_ms;
    logic              arm_switch_on;
    logic              is_armed;
    logic              link_ok;
    logic              failsafe_on;
    logic              gesture_blocked;
  } tick_t;

  // status flags of one result
  typedef struct packed {
    logic throttle_under_min;
    logic arm_attempt;
    logic arm_attempt_reset;
    logic disarm_request;
    logic calibrate_request;
    logic save_request;
  } flags_t;

endpackage

[rtl/rcsg_encode.sv]
module rcsg_encode (
  input  logic [rcsg_pkg::ValueW-1:0] roll_value,
  input  logic [rcsg_pkg::ValueW-1:0] pitch_value,
  input  logic [rcsg_pkg::ValueW-1:0] yaw_value,
  input  logic [rcsg_pkg::ValueW-1:0] throttle_value,
  input  logic [rcsg_pkg::ValueW-1:0] min_check,
  input  logic [rcsg_pkg::ValueW-1:0] max_check,
  output logic [rcsg_pkg::CodeW-1:0]  stick_code,
  output logic                        throttle_under_min
);

  logic [rcsg_pkg::ValueW-1:0] chan [4];

  // roll lowest, throttle highest
  assign chan[0] = roll_value;
  assign chan[1] = pitch_value;
  assign chan[2] = yaw_value;
  assign chan[3] = throttle_value;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      stick_code[2*i+1] = chan[i] > min_check;
      stick_code[2*i]   = chan[i] < max_check;
    end
  end

  assign throttle_under_min = throttle_value < min_check;

endmodule

[rtl/rcsg_track.sv]
module rcsg_track (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  rcsg_pkg::tick_t            tick,
  input  logic [rcsg_pkg::CodeW-1:0] code,
  input  logic                       throttle_under_min,
  output logic                       res_valid,
  input  logic                       res_taken,
  output logic [rcsg_pkg::CodeW-1:0] res_code,
  output rcsg_pkg::flags_t           res_flags
);

  logic [rcsg_pkg::CodeW-1:0]  held_code;
  logic [rcsg_pkg::TimeW-1:0]  hold_time_ms;
  logic [rcsg_pkg::CountW-1:0] disarm_count;
  logic                        gesture_done;

  logic [rcsg_pkg::TimeW-1:0]  hold_time_ms_next;
  logic [rcsg_pkg::CountW-1:0] disarm_count_next;
  logic                        gesture_done_next;
  logic [rcsg_pkg::TimeW:0]    hold_sum;
  logic                        same_code;
  logic                        done_kept;
  logic                        disarm;
  logic                        armed_now;
  logic                        fire;
  rcsg_pkg::flags_t            flags_next;

  always_comb begin
    same_code = code == held_code;
    hold_sum  = {1'b0, hold_time_ms} + {1'b0, tick.elapsed_ms};
    if (!same_code) begin
      hold_time_ms_next = '0;
    end else if (hold_sum <= rcsg_pkg::HOLD_MAX) begin
      hold_time_ms_next = hold_sum[rcsg_pkg::TimeW-1:0];
    end else begin
      hold_time_ms_next = hold_time_ms;
    end
    done_kept = same_code && gesture_done;

    disarm_count_next = disarm_count;
    disarm = 1'b0;
    if (tick.arm_switch_on) begin
      disarm_count_next = '0;
    end else if (tick.is_armed && tick.link_ok && !tick.failsafe_on) begin
      if (disarm_count != rcsg_pkg::COUNT_MAX) begin
        disarm_count_next = disarm_count + 1'b1;
      end
      disarm = disarm_count_next > rcsg_pkg::DISARM_TICK_LIMIT;
    end
    armed_now = tick.is_armed && !disarm;

    fire = !armed_now && !done_kept && !tick.gesture_blocked &&
           (hold_time_ms_next > rcsg_pkg::HOLD_DELAY_MS);
    gesture_done_next = fire || done_kept;

    flags_next.throttle_under_min = throttle_under_min;
    flags_next.arm_attempt        = tick.arm_switch_on;
    flags_next.arm_attempt_reset  = !tick.arm_switch_on;
    flags_next.disarm_request     = disarm;
    flags_next.calibrate_request  = fire && (code == rcsg_pkg::CODE_CALIBRATE);
    flags_next.save_request       = fire && (code == rcsg_pkg::CODE_SAVE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_code    <= '0;
      hold_time_ms <= '0;
      disarm_count <= '0;
      gesture_done <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (advance) begin
        held_code    <= code;
        hold_time_ms <= hold_time_ms_next;
        disarm_count <= disarm_count_next;
        gesture_done <= gesture_done_next;
        res_valid    <= 1'b1;
      end else if (res_taken) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_code  <= code;
      res_flags <= flags_next;
    end
  end

endmodule

[rtl/rc_stick_gesture_detector.sv]
// order: an accepted tick is captured in the input register and then moves to the
//   result register; it waits in the input register only while the result channel is stalled
// throughput: one tick per cycle while not stalled; the input register and the result
//   register form a two-entry pipeline, so a new tick is taken while a result waits
// reset: synchronous, active high; clears hold timer, held code, disarm counter,
//   one-shot flag and both valid flags, and restores min_check 1050, max_check 1900
module rc_stick_gesture_detector (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcsg_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [rcsg_pkg::ValueW-1:0]         cfg_data,
  // tick input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rcsg_pkg::ValueW-1:0]         roll_value,
  input  logic [rcsg_pkg::ValueW-1:0]         pitch_value,
  input  logic [rcsg_pkg::ValueW-1:0]         yaw_value,
  input  logic [rcsg_pkg::ValueW-1:0]         throttle_value,
  input  logic [rcsg_pkg::TimeW-1:0]          elapsed_ms,
  input  logic                                arm_switch_on,
  input  logic                                is_armed,
  input  logic                                link_ok,
  input  logic                                failsafe_on,
  input  logic                                gesture_blocked,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rcsg_pkg::CodeW-1:0]          stick_code,
  output logic                                throttle_under_min,
  output logic                                arm_attempt,
  output logic                                arm_attempt_reset,
  output logic                                disarm_request,
  output logic                                calibrate_request,
  output logic                                save_request
);

  // threshold registers, always writable
  logic [rcsg_pkg::ValueW-1:0] min_check;
  logic [rcsg_pkg::ValueW-1:0] max_check;

  // input register stage
  logic            tick_valid;
  rcsg_pkg::tick_t tick;
  logic            in_take;

  // pipeline control
  logic advance;
  logic res_taken;

  // stick code of the registered tick
  logic [rcsg_pkg::CodeW-1:0] code;
  logic                       thr_low;
  rcsg_pkg::flags_t           res_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_check <= rcsg_pkg::MIN_CHECK_RESET;
      max_check <= rcsg_pkg::MAX_CHECK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcsg_pkg::REG_MIN_CHECK: min_check <= cfg_data;
        rcsg_pkg::REG_MAX_CHECK: max_check <= cfg_data;
        default: ;
      endcase
    end
  end

  // the result register frees up when empty or when its transaction completes
  assign res_taken = out_valid && !out_stall;
  assign advance   = tick_valid && (!out_valid || !out_stall);
  // hold off new ticks only while both stages are full and the output is stalled
  assign in_stall  = tick_valid && out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_take) begin
      tick_valid <= 1'b1;
    end else if (advance) begin
      tick_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tick.roll_value      <= roll_value;
      tick.pitch_value     <= pitch_value;
      tick.yaw_value       <= yaw_value;
      tick.throttle_value  <= throttle_value;
      tick.elapsed_ms      <= elapsed_ms;
      tick.arm_switch_on   <= arm_switch_on;
      tick.is_armed        <= is_armed;
      tick.link_ok         <= link_ok;
      tick.failsafe_on     <= failsafe_on;
      tick.gesture_blocked <= gesture_blocked;
    end
  end

  // per-channel threshold compare into the packed code
  rcsg_encode u_encode (
    .roll_value        (tick.roll_value),
    .pitch_value       (tick.pitch_value),
    .yaw_value         (tick.yaw_value),
    .throttle_value    (tick.throttle_value),
    .min_check         (min_check),
    .max_check         (max_check),
    .stick_code        (code),
    .throttle_under_min(thr_low)
  );

  // hold timer, disarm counter, one-shot gestures and the result register
  rcsg_track u_track (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .tick              (tick),
    .code              (code),
    .throttle_under_min(thr_low),
    .res_valid         (out_valid),
    .res_taken         (res_taken),
    .res_code          (stick_code),
    .res_flags         (res_flags)
  );

  assign throttle_under_min = res_flags.throttle_under_min;
  assign arm_attempt        = res_flags.arm_attempt;
  assign arm_attempt_reset  = res_flags.arm_attempt_reset;
  assign disarm_request     = res_flags.disarm_request;
  assign calibrate_request  = res_flags.calibrate_request;
  assign save_request       = res_flags.save_request;

endmodule

[rtl/rcsg_checker.sv]
`include "rc_stick_gesture_detector_macros.svh"

module rcsg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rcsg_pkg::CodeW-1:0] stick_code,
  input logic                       arm_attempt,
  input logic                       arm_attempt_reset,
  input logic                       disarm_request,
  input logic                       calibrate_request,
  input logic                       save_request
);

  `RCSG_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "stalled result dropped")
  `RCSG_ASSERT_SAME(a_arm_excl, out_valid, arm_attempt != arm_attempt_reset, "arm strobes clash")
  `RCSG_ASSERT_SAME(a_disarm_off, out_valid && disarm_request, arm_attempt_reset, "disarm with switch on")
  `RCSG_ASSERT_SAME(a_cal_code, out_valid && calibrate_request, stick_code == rcsg_pkg::CODE_CALIBRATE, "calibrate on wrong code")
  `RCSG_ASSERT_SAME(a_save_code, out_valid && save_request, stick_code == rcsg_pkg::CODE_SAVE, "save on wrong code")

endmodule

bind rc_stick_gesture_detector rcsg_checker u_rcsg_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .stick_code       (stick_code),
  .arm_attempt      (arm_attempt),
  .arm_attempt_reset(arm_attempt_reset),
  .disarm_request   (disarm_request),
  .calibrate_request(calibrate_request),
  .save_request     (save_request)
);

[dv/rc_stick_gesture_detector_test.sv]
`timescale 1ns / 100ps

module rc_stick_gesture_detector_test;

  typedef logic [rcsg_pkg::ValueW-1:0] value_t;
  typedef logic [rcsg_pkg::TimeW-1:0]  time_ms_t;
  typedef logic [rcsg_pkg::CodeW-1:0]  code_t;

  // stick values either side of the reset thresholds
  localparam value_t V_LO  = 12'd1000;
  localparam value_t V_MID = 12'd1500;
  localparam value_t V_HI  = 12'd2000;
  localparam value_t V_TOP = 12'd4095;

  // idling rates, in cycles of a hundred
  localparam int unsigned QUIET_PCT = 36;
  localparam int unsigned BUSY_PCT  = 87;
  localparam int unsigned MODE_A_END = 420;
  localparam int unsigned MODE_B_END = 840;

  localparam int unsigned PHASE_TICKS     = 200;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;

  typedef struct packed {
    code_t            code;
    rcsg_pkg::flags_t flags;
  } tick_result_t;

  typedef struct {
    rcsg_pkg::tick_t tick;
    bit              typed;
    tick_result_t    want;
  } stim_row_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rcsg_pkg::CfgIdxW-1:0]  cfg_index = '0;
  value_t                        cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  value_t                        roll_value = '0;
  value_t                        pitch_value = '0;
  value_t                        yaw_value = '0;
  value_t                        throttle_value = '0;
  time_ms_t                      elapsed_ms = '0;
  logic                          arm_switch_on = 1'b0;
  logic                          is_armed = 1'b0;
  logic                          link_ok = 1'b0;
  logic                          failsafe_on = 1'b0;
  logic                          gesture_blocked = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  code_t                         stick_code;
  logic                          throttle_under_min;
  logic                          arm_attempt;
  logic                          arm_attempt_reset;
  logic                          disarm_request;
  logic                          calibrate_request;
  logic                          save_request;

  rc_stick_gesture_detector dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .roll_value        (roll_value),
    .pitch_value       (pitch_value),
    .yaw_value         (yaw_value),
    .throttle_value    (throttle_value),
    .elapsed_ms        (elapsed_ms),
    .arm_switch_on     (arm_switch_on),
    .is_armed          (is_armed),
    .link_ok           (link_ok),
    .failsafe_on       (failsafe_on),
    .gesture_blocked   (gesture_blocked),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .stick_code        (stick_code),
    .throttle_under_min(throttle_under_min),
    .arm_attempt       (arm_attempt),
    .arm_attempt_reset (arm_attempt_reset),
    .disarm_request    (disarm_request),
    .calibrate_request (calibrate_request),
    .save_request      (save_request)
  );

  // predictor's own copy of the thresholds and the gesture state
  value_t                         lo_thresh = rcsg_pkg::MIN_CHECK_RESET;
  value_t                         hi_thresh = rcsg_pkg::MAX_CHECK_RESET;
  code_t                          held_code = '0;
  time_ms_t                       hold_ms = '0;
  logic [rcsg_pkg::CountW-1:0]    disarm_ticks = '0;
  bit                             gesture_fired = 1'b0;

  tick_result_t pending_results[$];
  stim_row_t    directed_ticks[$];
  int unsigned  ticks_sent = 0;
  int unsigned  error_count = 0;
  bit           hold_off_pending = 1'b0;
  int unsigned  hold_left = 0;
  int unsigned  quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // idling schedule: sender light / receiver heavy, then swapped, then none
  function automatic int unsigned sender_idle_pct();
    if (ticks_sent < MODE_A_END) return QUIET_PCT;
    if (ticks_sent < MODE_B_END) return BUSY_PCT;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (ticks_sent < MODE_A_END) return BUSY_PCT;
    if (ticks_sent < MODE_B_END) return QUIET_PCT;
    return 0;
  endfunction

  // expected result of one tick; advances the predictor state
  function automatic tick_result_t predict_tick(input rcsg_pkg::tick_t t);
    logic [4*rcsg_pkg::ValueW-1:0] chans;
    value_t                        v;
    code_t                         code;
    logic                          armed_now;
    tick_result_t                  r;
    chans = {t.throttle_value, t.yaw_value, t.pitch_value, t.roll_value};
    code = '0;
    r = '0;
    armed_now = t.is_armed;
    // roll in the low pair, throttle in the high pair
    for (int ch = 0; ch < 4; ch++) begin
      v = chans[ch*rcsg_pkg::ValueW +: rcsg_pkg::ValueW];
      code[2*ch +: 2] = {v > lo_thresh, v < hi_thresh};
    end
    // hold timer only grows while the sum stays within range
    if (code == held_code) begin
      if ({1'b0, hold_ms} + {1'b0, t.elapsed_ms} <= rcsg_pkg::HOLD_MAX)
        hold_ms = hold_ms + t.elapsed_ms;
    end else begin
      hold_ms = '0;
      gesture_fired = 1'b0;
    end
    held_code = code;
    if (t.arm_switch_on) begin
      disarm_ticks = '0;
      r.flags.arm_attempt = 1'b1;
    end else begin
      r.flags.arm_attempt_reset = 1'b1;
      if (t.is_armed && t.link_ok && !t.failsafe_on) begin
        if (disarm_ticks < rcsg_pkg::COUNT_MAX) disarm_ticks++;
        if (disarm_ticks > rcsg_pkg::DISARM_TICK_LIMIT) begin
          r.flags.disarm_request = 1'b1;
          // a disarm in this tick opens the gesture check of the same tick
          armed_now = 1'b0;
        end
      end
    end
    // one-shot gesture, set even when the code matches neither gesture
    if (!armed_now && !gesture_fired && hold_ms > rcsg_pkg::HOLD_DELAY_MS &&
        !t.gesture_blocked) begin
      gesture_fired = 1'b1;
      r.flags.calibrate_request = (code == rcsg_pkg::CODE_CALIBRATE);
      r.flags.save_request = (code == rcsg_pkg::CODE_SAVE);
    end
    r.code = code;
    r.flags.throttle_under_min = (t.throttle_value < lo_thresh);
    return r;
  endfunction

  // a stick value that falls in the wanted position, near a threshold at times
  function automatic value_t value_for(input logic [1:0] want);
    value_t v;
    v = '0;
    for (int n = 0; n < 32; n++) begin
      case ($urandom_range(2))
        0: v = value_t'($urandom_range(4095));
        1: v = value_t'(lo_thresh + $urandom_range(2) - 1);
        default: v = value_t'(hi_thresh + $urandom_range(2) - 1);
      endcase
      if ({v > lo_thresh, v < hi_thresh} == want) return v;
    end
    return v;
  endfunction

  // offer one tick, hold it until taken, then record what it should produce
  task automatic send_tick(input stim_row_t row);
    while ($urandom_range(99) < sender_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {roll_value, pitch_value, yaw_value, throttle_value, elapsed_ms, arm_switch_on,
     is_armed, link_ok, failsafe_on, gesture_blocked} <= row.tick;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    if (row.typed) begin
      void'(predict_tick(row.tick));
      pending_results.push_back(row.want);
    end else begin
      pending_results.push_back(predict_tick(row.tick));
    end
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both thresholds, back to back on the configuration channel
  task automatic write_thresholds(input value_t lo, input value_t hi);
    cfg_valid <= 1'b1;
    cfg_index <= rcsg_pkg::REG_MIN_CHECK;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    lo_thresh = lo;
    cfg_index <= rcsg_pkg::REG_MAX_CHECK;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    hi_thresh = hi;
    cfg_valid <= 1'b0;
  endtask

  // bursts of held gestures and switch-off runs, with some pure noise
  task automatic random_ticks(input int unsigned n_ticks, input bit squeeze,
                              input bit long_run);
    int unsigned     done_here;
    int unsigned     kind;
    int unsigned     len;
    bit              steady;
    code_t           target;
    logic [95:0]     noise;
    rcsg_pkg::tick_t t;
    done_here = 0;
    while (done_here < n_ticks) begin
      kind = $urandom_range(9);
      len = $urandom_range(9, 2);
      // one long switch-off run takes the disarm counter to saturation
      if (long_run && done_here == 0) begin
        kind = 5;
        len = 270;
      end
      steady = (len > 100);
      case ($urandom_range(3))
        0: target = rcsg_pkg::CODE_CALIBRATE;
        1: target = rcsg_pkg::CODE_SAVE;
        default: target = code_t'($urandom);
      endcase
      for (int k = 0; k < len; k++) begin
        noise = {$urandom, $urandom, $urandom};
        t = noise[$bits(rcsg_pkg::tick_t)-1:0];
        if (kind < 8) begin
          t.roll_value     = value_for(target[1:0]);
          t.pitch_value    = value_for(target[3:2]);
          t.yaw_value      = value_for(target[5:4]);
          t.throttle_value = value_for(target[7:6]);
          t.elapsed_ms = ($urandom_range(19) == 0)
                       ? time_ms_t'($urandom_range(32767, 16000))
                       : time_ms_t'($urandom_range(40));
        end
        if (kind < 5) begin
          // held gesture, mostly disarmed
          t.arm_switch_on   = ($urandom_range(7) == 0);
          t.is_armed        = ($urandom_range(5) == 0);
          t.link_ok         = 1'b1;
          t.failsafe_on     = ($urandom_range(7) == 0);
          t.gesture_blocked = ($urandom_range(7) == 0);
        end else if (kind < 8) begin
          // switch-off run while armed
          t.arm_switch_on   = steady ? 1'b0
                            : (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(11) == 0);
          t.is_armed        = 1'b1;
          t.link_ok         = steady || ($urandom_range(9) != 0);
          t.failsafe_on     = !steady && ($urandom_range(9) == 0);
          t.gesture_blocked = ($urandom_range(9) == 0);
        end
        if (squeeze && done_here == 30) hold_off_pending = 1'b1;
        send_tick('{t, 1'b0, '0});
        done_here++;
      end
    end
  endtask

  // main sequence: reset, directed table, then random phases
  initial begin
    // extremes after reset, with their results read straight off the spec
    directed_ticks.push_back('{rcsg_pkg::tick_t'{0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
                               1'b1, tick_result_t'{8'h55, 6'b101000}});
    directed_ticks.push_back('{rcsg_pkg::tick_t'{V_TOP, V_TOP, V_TOP, V_TOP, 15'h7fff,
                                                 1, 0, 1, 0, 0},
                               1'b1, tick_result_t'{8'haa, 6'b010000}});
    // timer fills to its top; a held code that is no gesture still uses the one-shot
    directed_ticks.push_back('{rcsg_pkg::tick_t'{V_TOP, V_TOP, V_TOP, V_TOP, 15'h7fff,
                                                 1, 0, 1, 0, 0},
                               1'b1, tick_result_t'{8'haa, 6'b010000}});
    // timer saturates
    directed_ticks.push_back('{rcsg_pkg::tick_t'{V_TOP, V_TOP, V_TOP, V_TOP, 15'h7fff,
                                                 1, 0, 1, 0, 0},
                               1'b0, '0});
    // calibrate held: fires once, past the hold delay
    repeat (5)
      directed_ticks.push_back('{rcsg_pkg::tick_t'{V_LO, V_LO, V_HI, V_LO, 20, 0, 0, 1, 0, 0},
                                 1'b0, '0});
    // save held: no fire at exactly the hold delay, blocked once, then fires
    repeat (3)
      directed_ticks.push_back('{rcsg_pkg::tick_t'{V_HI, V_LO, V_LO, V_LO, 25, 0, 0, 1, 0, 0},
                                 1'b0, '0});
    directed_ticks.push_back('{rcsg_pkg::tick_t'{V_HI, V_LO, V_LO, V_LO, 25, 0, 0, 1, 0, 1},
                               1'b0, '0});
    directed_ticks.push_back('{rcsg_pkg::tick_t'{V_HI, V_LO, V_LO, V_LO, 25, 0, 0, 1, 0, 0},
                               1'b0, '0});
    // armed with no signal: neither counts nor fires
    repeat (2)
      directed_ticks.push_back('{rcsg_pkg::tick_t'{V_LO, V_LO, V_HI, V_LO, 100, 0, 1, 0, 0, 0},
                                 1'b0, '0});
    // failsafe stops the disarm count
    directed_ticks.push_back('{rcsg_pkg::tick_t'{V_LO, V_LO, V_HI, V_LO, 100, 0, 1, 1, 1, 0},
                               1'b0, '0});
    // fourth switch-off tick disarms, and calibrate fires in the same tick
    repeat (4)
      directed_ticks.push_back('{rcsg_pkg::tick_t'{V_LO, V_LO, V_HI, V_LO, 100, 0, 1, 1, 0, 0},
                                 1'b0, '0});
    // switch back on clears the count
    directed_ticks.push_back('{rcsg_pkg::tick_t'{V_MID, V_MID, V_MID, V_MID, 10, 1, 1, 1, 0, 0},
                               1'b0, '0});
    directed_ticks.push_back('{rcsg_pkg::tick_t'{V_TOP, 0, V_TOP, 0, 10, 0, 1, 1, 0, 0},
                               1'b0, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ticks[i]) send_tick(directed_ticks[i]);

    // threshold settings: full span, inverted, equal, random, reset values, narrow
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: write_thresholds(12'd0, 12'd4095);
        1: write_thresholds(12'd4095, 12'd0);
        2: write_thresholds(12'd2048, 12'd2048);
        3: write_thresholds(value_t'($urandom_range(4095)), value_t'($urandom_range(4095)));
        4: write_thresholds(rcsg_pkg::MIN_CHECK_RESET, rcsg_pkg::MAX_CHECK_RESET);
        default: write_thresholds(12'd1200, 12'd1800);
      endcase
      // long hold-off in the last phase, where the sender never idles
      random_ticks(PHASE_TICKS, p == NUM_PHASES - 1, p == 4);
    end

    drain();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: check each transaction, then choose next cycle's stall
  always @(posedge clk) begin
    tick_result_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.code                     = stick_code;
        got.flags.throttle_under_min = throttle_under_min;
        got.flags.arm_attempt        = arm_attempt;
        got.flags.arm_attempt_reset  = arm_attempt_reset;
        got.flags.disarm_request     = disarm_request;
        got.flags.calibrate_request  = calibrate_request;
        got.flags.save_request       = save_request;
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t unexpected result: expected none, actual %h", $time, got);
        end else begin
          if (got != pending_results[0]) begin
            error_count++;
            $display("%0t result mismatch: expected %h, actual %h",
                     $time, pending_results[0], got);
          end
          void'(pending_results.pop_front());
        end
      end
      // long hold-off lets the pipeline fill and push back on the input
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct());
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rcsg_pkg.sv
rtl/rcsg_encode.sv
rtl/rcsg_track.sv
rtl/rc_stick_gesture_detector.sv
rtl/rcsg_checker.sv
dv/rc_stick_gesture_detector_test.sv
